[hw/rtl/bbtc_pkg.sv]
// Shared types and constants of the bump, back up and turn controller.
`default_nettype none

package bbtc_pkg;

  // Controller mode, as reported on the result channel
  typedef enum logic [1:0] {
    MODE_FWD  = 2'd0,
    MODE_BACK = 2'd1,
    MODE_TURN = 2'd2
  } mode_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_VEL        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_VEL        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_TICKS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN      = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_MAX       = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_MIN       = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_TOL    = 8'd7;

  // Configuration reset values
  localparam logic signed [15:0] RST_FWD_VEL        = 16'sd328;
  localparam logic signed [15:0] RST_REV_VEL        = -16'sd328;
  localparam logic [15:0]        RST_BACKUP_TICKS   = 16'd125;
  localparam logic signed [15:0] RST_TURN_ANGLE     = 16'sd16384;
  localparam logic [15:0]        RST_TURN_GAIN      = 16'd141;
  localparam logic [14:0]        RST_SPIN_MAX       = 15'd2867;
  localparam logic [14:0]        RST_SPIN_MIN       = 15'd492;
  localparam logic [14:0]        RST_HEADING_TOL    = 15'd364;

  localparam logic [15:0] HITS_MAX = 16'hFFFF;

  // Live configuration, from the register file to the datapath
  typedef struct packed {
    logic signed [15:0] fwd_vel;
    logic signed [15:0] rev_vel;
    logic [15:0]        backup_ticks;
    logic signed [15:0] turn_angle;
    logic [15:0]        turn_gain;
    logic [14:0]        spin_max;
    logic [14:0]        spin_min;
    logic [14:0]        heading_tol;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic [15:0]        hits;
    logic [1:0]         mode;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/bbtc_in_if.sv]
// Input channel: one control tick with bumper byte and yaw.
`default_nettype none

interface bbtc_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         bump_byte;
  logic signed [15:0] yaw;

  modport source (output valid, output bump_byte, output yaw, input ready);
  modport sink (input valid, input bump_byte, input yaw, output ready);
endinterface

`default_nettype wire

[hw/rtl/bbtc_out_if.sv]
// Result channel: velocity commands, hit count and mode.
`default_nettype none

interface bbtc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_cmd;
  logic signed [15:0] angular_cmd;
  logic [15:0]        hits;
  logic [1:0]         mode;

  modport source (output valid, output linear_cmd, output angular_cmd, output hits,
                  output mode, input ready);
  modport sink (input valid, input linear_cmd, input angular_cmd, input hits,
                input mode, output ready);
endinterface

`default_nettype wire

[hw/rtl/bbtc_cfg_if.sv]
// Configuration write channel: register index and write data.
`default_nettype none

interface bbtc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/bump_backup_turn_controller.sv]
// Top level of the bump, back up and turn obstacle controller.
//
// Each input transfer is one control tick (bumper byte, yaw as a binary angle
// with pi = 32768) and yields exactly one result transfer (linear and angular
// command, hit count, mode after the tick). A tick is captured in an input
// register, evaluated combinationally by the mode logic and the gain
// multiplier, and is registered in the output register when that register
// is free or drains; result valid comes from the output register. A new tick
// is taken every cycle as long as the result side keeps up. Configuration
// writes take effect at once and are always accepted; write them only while
// no tick is in flight.
`default_nettype none

module bump_backup_turn_controller (
  input  wire logic  clk,
  input  wire logic  rst,
  bbtc_in_if.sink    in_ch,
  bbtc_out_if.source out_ch,
  bbtc_cfg_if.sink   cfg
);

  bbtc_pkg::cfg_t    regs;
  bbtc_pkg::result_t result;

  logic               s1_valid;
  logic               s1_bump;
  logic signed [15:0] s1_yaw;
  logic               out_valid;
  bbtc_pkg::result_t  out_data;

  logic out_free;
  logic advance;
  logic in_take;

  bbtc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Handshake: stage 1 moves on when the output register is free or drains
  assign out_free     = !out_valid || out_ch.ready;
  assign advance      = s1_valid && out_free;
  assign in_ch.ready  = !s1_valid || out_free;
  assign in_take      = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_bump <= in_ch.bump_byte[0];
      s1_yaw  <= in_ch.yaw;
    end
  end

  bbtc_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .bump    (s1_bump),
    .yaw     (s1_yaw),
    .regs    (regs),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= result;
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.linear_cmd  = out_data.linear_cmd;
  assign out_ch.angular_cmd = out_data.angular_cmd;
  assign out_ch.hits        = out_data.hits;
  assign out_ch.mode        = out_data.mode;

endmodule

`default_nettype wire

[hw/rtl/bbtc_cfg_regs.sv]
// Configuration register file of the controller.
`default_nettype none

module bbtc_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst,
  bbtc_cfg_if.sink      cfg,
  output bbtc_pkg::cfg_t regs
);

  // Always take a write; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fwd_vel      <= bbtc_pkg::RST_FWD_VEL;
      regs.rev_vel      <= bbtc_pkg::RST_REV_VEL;
      regs.backup_ticks <= bbtc_pkg::RST_BACKUP_TICKS;
      regs.turn_angle   <= bbtc_pkg::RST_TURN_ANGLE;
      regs.turn_gain    <= bbtc_pkg::RST_TURN_GAIN;
      regs.spin_max     <= bbtc_pkg::RST_SPIN_MAX;
      regs.spin_min     <= bbtc_pkg::RST_SPIN_MIN;
      regs.heading_tol  <= bbtc_pkg::RST_HEADING_TOL;
    end else if (cfg.valid) begin
      case (cfg.index)
        bbtc_pkg::CFG_FWD_VEL:      regs.fwd_vel      <= $signed(cfg.data);
        bbtc_pkg::CFG_REV_VEL:      regs.rev_vel      <= $signed(cfg.data);
        bbtc_pkg::CFG_BACKUP_TICKS: regs.backup_ticks <= cfg.data;
        bbtc_pkg::CFG_TURN_ANGLE:   regs.turn_angle   <= $signed(cfg.data);
        bbtc_pkg::CFG_TURN_GAIN:    regs.turn_gain    <= cfg.data;
        bbtc_pkg::CFG_SPIN_MAX:     regs.spin_max     <= cfg.data[14:0];
        bbtc_pkg::CFG_SPIN_MIN:     regs.spin_min     <= cfg.data[14:0];
        bbtc_pkg::CFG_HEADING_TOL:  regs.heading_tol  <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bbtc_turn_cmd.sv]
// Proportional angular command: gain multiply, floor shift, clamp and minimum lift.
`default_nettype none

module bbtc_turn_cmd (
  input  wire logic signed [15:0] err,
  input  wire logic [15:0]        turn_gain,
  input  wire logic [14:0]        spin_max,
  input  wire logic [14:0]        spin_min,
  output logic signed [15:0]      cmd
);

  logic signed [16:0] gain_s;
  logic signed [32:0] prod;
  logic signed [24:0] scaled;
  logic signed [24:0] mx;
  logic signed [24:0] mn;
  logic signed [24:0] clamped;
  logic signed [24:0] mag;
  logic signed [24:0] lifted;

  // Multiply and floor-divide by 256 (arithmetic shift rounds toward minus infinity)
  assign gain_s = $signed({1'b0, turn_gain});
  assign prod   = err * gain_s;
  assign scaled = prod[32:8];

  assign mx = $signed({10'b0, spin_max});
  assign mn = $signed({10'b0, spin_min});

  // Clamp to +-max, then lift small magnitudes to min (min wins if above max)
  always_comb begin
    if (scaled > mx) begin
      clamped = mx;
    end else if (scaled < -mx) begin
      clamped = -mx;
    end else begin
      clamped = scaled;
    end
    mag = clamped[24] ? -clamped : clamped;
    if (mag < mn) begin
      lifted = clamped[24] ? -mn : mn;
    end else begin
      lifted = clamped;
    end
  end

  assign cmd = lifted[15:0];

endmodule

`default_nettype wire

[hw/rtl/bbtc_step.sv]
// Mode state machine and tick datapath: one control tick per advance.
`default_nettype none

module bbtc_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic               bump,
  input  wire logic signed [15:0] yaw,
  input  wire bbtc_pkg::cfg_t     regs,
  output bbtc_pkg::result_t       result
);

  bbtc_pkg::mode_t mode_reg;
  bbtc_pkg::mode_t mode_next;
  logic            last_bump;
  logic [15:0]     hit_total;
  logic [15:0]     hit_total_next;
  logic [15:0]     backup_elapsed;
  logic [15:0]     backup_elapsed_next;
  logic [15:0]     target_heading;
  logic [15:0]     target_heading_next;

  logic               edge_seen;
  logic               backup_running;
  logic signed [15:0] err;
  logic [16:0]        err_mag;
  logic               turn_active;
  logic signed [15:0] turn_ang;
  logic signed [15:0] lin;
  logic signed [15:0] ang;

  assign edge_seen      = bump && !last_bump;
  assign backup_running = backup_elapsed < regs.backup_ticks;

  // Heading error wraps in the binary angle circle
  assign err         = $signed(target_heading - yaw);
  assign err_mag     = err[15] ? (17'd0 - {err[15], err}) : {1'b0, err};
  assign turn_active = err_mag > {2'b00, regs.heading_tol};

  bbtc_turn_cmd u_turn_cmd (
    .err       (err),
    .turn_gain (regs.turn_gain),
    .spin_max  (regs.spin_max),
    .spin_min  (regs.spin_min),
    .cmd       (turn_ang)
  );

  // Next mode
  always_comb begin
    case (mode_reg)
      bbtc_pkg::MODE_BACK: mode_next = backup_running ? bbtc_pkg::MODE_BACK
                                                      : bbtc_pkg::MODE_TURN;
      bbtc_pkg::MODE_TURN: mode_next = turn_active ? bbtc_pkg::MODE_TURN
                                                   : bbtc_pkg::MODE_FWD;
      default:             mode_next = edge_seen ? bbtc_pkg::MODE_BACK
                                                 : bbtc_pkg::MODE_FWD;
    endcase
  end

  // Velocity commands; transition ticks give zero
  always_comb begin
    lin = '0;
    ang = '0;
    case (mode_reg)
      bbtc_pkg::MODE_BACK: begin
        if (backup_running) lin = regs.rev_vel;
      end
      bbtc_pkg::MODE_TURN: begin
        if (turn_active) ang = turn_ang;
      end
      default: begin
        if (!edge_seen) lin = regs.fwd_vel;
      end
    endcase
  end

  // Counters and target heading
  always_comb begin
    hit_total_next      = hit_total;
    backup_elapsed_next = backup_elapsed;
    target_heading_next = target_heading;
    case (mode_reg)
      bbtc_pkg::MODE_BACK: begin
        if (backup_running) begin
          backup_elapsed_next = backup_elapsed + 16'd1;
        end else begin
          target_heading_next = yaw + regs.turn_angle;
        end
      end
      bbtc_pkg::MODE_TURN: ;
      default: begin
        if (edge_seen) begin
          if (hit_total != bbtc_pkg::HITS_MAX) hit_total_next = hit_total + 16'd1;
          backup_elapsed_next = '0;
        end
      end
    endcase
  end

  // Advance state on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= bbtc_pkg::MODE_FWD;
      last_bump      <= 1'b0;
      hit_total      <= '0;
      backup_elapsed <= '0;
      target_heading <= '0;
    end else if (advance) begin
      mode_reg       <= mode_next;
      last_bump      <= bump;
      hit_total      <= hit_total_next;
      backup_elapsed <= backup_elapsed_next;
      target_heading <= target_heading_next;
    end
  end

  assign result.linear_cmd  = lin;
  assign result.angular_cmd = ang;
  assign result.hits        = hit_total_next;
  assign result.mode        = mode_next;

endmodule

`default_nettype wire
